### hdl/variable_record_ring_allocator_top_assert.svh
// Assertion macros for the record ring allocator.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef VARIABLE_RECORD_RING_ALLOCATOR_TOP_ASSERT_SVH
`define VARIABLE_RECORD_RING_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define VRRA_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define VRRA_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/vrra_pkg.sv
// Shared types and constants for the record ring allocator.
// No dependencies.
package vrra_pkg;

    localparam int BUF_BYTES = 4096;
    localparam int ADDR_W    = $clog2(BUF_BYTES);
    localparam int PTR_W     = ADDR_W + 1;
    localparam int SIZE_W    = 8;
    localparam int TYPE_W    = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 13;

    localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BYTES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_DUR_COL  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_INSTANT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_COUNTER  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_LINK     = 3'd5;

    localparam logic [TYPE_W-1:0] TYPE_EMPTY        = 3'd0;
    localparam logic [TYPE_W-1:0] TYPE_DURATION     = 3'd1;
    localparam logic [TYPE_W-1:0] TYPE_DURATION_COL = 3'd2;
    localparam logic [TYPE_W-1:0] TYPE_INSTANT      = 3'd3;
    localparam logic [TYPE_W-1:0] TYPE_COUNTER      = 3'd4;
    localparam logic [TYPE_W-1:0] TYPE_LINK         = 3'd5;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CALC,
        ST_WALK,
        ST_EVAL,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic clear_step;
        logic accept;
        logic calc;
        logic walk_rd;
        logic walk_step;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic ignore;
        logic in_range;
        logic step_zero;
        logic out_free;
    } status_t;

endpackage

### hdl/vrra_ctrl.sv
// Controller FSM for the record ring allocator.
// Depends on vrra_pkg; drives commands into vrra_datapath.
module vrra_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  vrra_pkg::status_t sts,
    output vrra_pkg::cmd_t    cmd
);

    vrra_pkg::state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= vrra_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            vrra_pkg::ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done) begin
                    state_next = vrra_pkg::ST_IDLE;
                end
            end
            vrra_pkg::ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
                if (s_tvalid) begin
                    state_next = vrra_pkg::ST_CALC;
                end
            end
            vrra_pkg::ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = sts.ignore ? vrra_pkg::ST_FINISH : vrra_pkg::ST_WALK;
            end
            vrra_pkg::ST_WALK: begin
                if (sts.in_range) begin
                    cmd.walk_rd = 1'b1;
                    state_next  = vrra_pkg::ST_EVAL;
                end else begin
                    state_next  = vrra_pkg::ST_FINISH;
                end
            end
            vrra_pkg::ST_EVAL: begin
                cmd.walk_step = 1'b1;
                state_next    = sts.step_zero ? vrra_pkg::ST_FINISH : vrra_pkg::ST_WALK;
            end
            vrra_pkg::ST_FINISH: begin
                if (sts.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = vrra_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = vrra_pkg::ST_CLEAR;
            end
        endcase
    end

endmodule

### hdl/vrra_datapath.sv
// Datapath for the record ring allocator: config registers, pointers,
// tag memory and result register. Depends on vrra_pkg and the assert header.
`include "variable_record_ring_allocator_top_assert.svh"

module vrra_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  vrra_pkg::cmd_t                     cmd,
    output vrra_pkg::status_t                  sts,
    input  logic [vrra_pkg::TYPE_W-1:0]        s_record_type,
    input  logic                               cfg_valid,
    input  logic [vrra_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [vrra_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                               m_tready,
    output logic                               m_tvalid,
    output logic [vrra_pkg::ADDR_W-1:0]        m_entry_offset,
    output logic [vrra_pkg::ADDR_W-1:0]        m_oldest_offset,
    output logic [vrra_pkg::PTR_W-1:0]         m_next_offset,
    output logic                               m_wrapped
);

    localparam int ADDR_W = vrra_pkg::ADDR_W;
    localparam int PTR_W  = vrra_pkg::PTR_W;
    localparam int SIZE_W = vrra_pkg::SIZE_W;
    localparam int TYPE_W = vrra_pkg::TYPE_W;
    localparam logic [PTR_W-1:0] RING_MAX = PTR_W'(vrra_pkg::BUF_BYTES);

    // configuration
    logic [PTR_W-1:0]  buf_bytes_reg;
    logic [SIZE_W-1:0] size_dur_reg, size_dcol_reg, size_inst_reg, size_cnt_reg, size_link_reg;

    // pointers and per-request working registers
    logic [PTR_W-1:0]  wp_reg;
    logic [ADDR_W-1:0] oldest_reg;
    logic [TYPE_W-1:0] rtype_reg;
    logic [ADDR_W-1:0] entry_reg;
    logic [PTR_W-1:0]  next_reg;
    logic [PTR_W-1:0]  start_reg;
    logic              wrap_reg;
    logic              ign_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;

    // tag memory
    logic [TYPE_W-1:0] tag_mem [vrra_pkg::BUF_BYTES];
    logic [TYPE_W-1:0] tag_rdata_reg;
    logic              tag_we;
    logic [ADDR_W-1:0] tag_waddr;
    logic [TYPE_W-1:0] tag_wdata;

    // result register
    logic              m_tvalid_reg;
    logic [ADDR_W-1:0] m_entry_reg, m_oldest_reg;
    logic [PTR_W-1:0]  m_next_reg;
    logic              m_wrap_reg;

    logic [PTR_W-1:0]  ring;
    logic [SIZE_W-1:0] rsize, step;
    logic [PTR_W-1:0]  room;
    logic              ignore, nofit;
    logic [PTR_W-1:0]  start_fin;

    function automatic logic [SIZE_W-1:0] size_of(input logic [TYPE_W-1:0] t,
                                                  input logic [SIZE_W-1:0] s1,
                                                  input logic [SIZE_W-1:0] s2,
                                                  input logic [SIZE_W-1:0] s3,
                                                  input logic [SIZE_W-1:0] s4,
                                                  input logic [SIZE_W-1:0] s5);
        logic [SIZE_W-1:0] r;
        case (t)
            vrra_pkg::TYPE_DURATION:     r = s1;
            vrra_pkg::TYPE_DURATION_COL: r = s2;
            vrra_pkg::TYPE_INSTANT:      r = s3;
            vrra_pkg::TYPE_COUNTER:      r = s4;
            vrra_pkg::TYPE_LINK:         r = s5;
            default:                     r = '0;
        endcase
        return r;
    endfunction

    always_comb begin
        if (buf_bytes_reg == '0) begin
            ring = PTR_W'(1);
        end else if (buf_bytes_reg > RING_MAX) begin
            ring = RING_MAX;
        end else begin
            ring = buf_bytes_reg;
        end
        rsize  = size_of(rtype_reg, size_dur_reg, size_dcol_reg, size_inst_reg,
                         size_cnt_reg, size_link_reg);
        step   = size_of(tag_rdata_reg, size_dur_reg, size_dcol_reg, size_inst_reg,
                         size_cnt_reg, size_link_reg);
        room   = ring - wp_reg;
        ignore = (rsize == '0) || ({{(PTR_W-SIZE_W){1'b0}}, rsize} > ring);
        nofit  = (wp_reg > ring) || (room < {{(PTR_W-SIZE_W){1'b0}}, rsize});
        start_fin = (start_reg >= ring) ? '0 : start_reg;
    end

    assign sts.clear_done = (clr_cnt_reg == '1);
    assign sts.ignore     = ignore;
    assign sts.in_range   = (start_reg >= {1'b0, entry_reg}) && (start_reg < next_reg);
    assign sts.step_zero  = (step == '0);
    assign sts.out_free   = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_bytes_reg <= RING_MAX;
            size_dur_reg  <= 8'd24;
            size_dcol_reg <= 8'd32;
            size_inst_reg <= 8'd24;
            size_cnt_reg  <= 8'd24;
            size_link_reg <= 8'd16;
        end else if (cfg_valid) begin
            case (cfg_index)
                vrra_pkg::REG_BUFFER_BYTES:  buf_bytes_reg <= cfg_data;
                vrra_pkg::REG_SIZE_DURATION: size_dur_reg  <= cfg_data[SIZE_W-1:0];
                vrra_pkg::REG_SIZE_DUR_COL:  size_dcol_reg <= cfg_data[SIZE_W-1:0];
                vrra_pkg::REG_SIZE_INSTANT:  size_inst_reg <= cfg_data[SIZE_W-1:0];
                vrra_pkg::REG_SIZE_COUNTER:  size_cnt_reg  <= cfg_data[SIZE_W-1:0];
                vrra_pkg::REG_SIZE_LINK:     size_link_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg       <= '0;
            oldest_reg   <= '0;
            clr_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.clear_step) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cmd.commit) begin
                m_tvalid_reg <= 1'b1;
                if (!ign_reg) begin
                    wp_reg     <= next_reg;
                    oldest_reg <= start_fin[ADDR_W-1:0];
                end
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            rtype_reg <= s_record_type;
        end
        if (cmd.calc) begin
            ign_reg <= ignore;
            if (ignore) begin
                entry_reg <= '0;
                start_reg <= {1'b0, oldest_reg};
                next_reg  <= wp_reg;
                wrap_reg  <= 1'b0;
            end else if (nofit) begin
                entry_reg <= '0;
                start_reg <= '0;
                next_reg  <= {{(PTR_W-SIZE_W){1'b0}}, rsize};
                wrap_reg  <= 1'b1;
            end else begin
                entry_reg <= wp_reg[ADDR_W-1:0];
                start_reg <= {1'b0, oldest_reg};
                next_reg  <= wp_reg + {{(PTR_W-SIZE_W){1'b0}}, rsize};
                wrap_reg  <= 1'b0;
            end
        end
        if (cmd.walk_step) begin
            start_reg <= (step == '0) ? '0 : start_reg + {{(PTR_W-SIZE_W){1'b0}}, step};
        end
        if (cmd.commit) begin
            m_entry_reg  <= entry_reg;
            m_oldest_reg <= ign_reg ? start_reg[ADDR_W-1:0] : start_fin[ADDR_W-1:0];
            m_next_reg   <= next_reg;
            m_wrap_reg   <= wrap_reg;
        end
    end

    always_comb begin
        tag_we    = 1'b0;
        tag_waddr = entry_reg;
        tag_wdata = rtype_reg;
        if (cmd.clear_step) begin
            tag_we    = 1'b1;
            tag_waddr = clr_cnt_reg;
            tag_wdata = vrra_pkg::TYPE_EMPTY;
        end else if (cmd.calc) begin
            // tail marker when the record wraps and the old write point lies inside the ring
            tag_we    = !ignore && nofit && (wp_reg < ring);
            tag_waddr = wp_reg[ADDR_W-1:0];
            tag_wdata = vrra_pkg::TYPE_EMPTY;
        end else if (cmd.commit) begin
            tag_we    = !ign_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (tag_we) begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        if (cmd.walk_rd) begin
            tag_rdata_reg <= tag_mem[start_reg[ADDR_W-1:0]];
        end
    end

    assign m_tvalid        = m_tvalid_reg;
    assign m_entry_offset  = m_entry_reg;
    assign m_oldest_offset = m_oldest_reg;
    assign m_next_offset   = m_next_reg;
    assign m_wrapped       = m_wrap_reg;

    `VRRA_ASSERT_IMP(a_wp_bound, aclk, aresetn, 1'b1, wp_reg <= RING_MAX, "write point past buffer")
    `VRRA_ASSERT_IMP(a_walk_addr, aclk, aresetn, cmd.walk_rd, start_reg < RING_MAX, "walk read out of range")
    `VRRA_ASSERT_IMP(a_no_overrun, aclk, aresetn, cmd.commit, !m_tvalid_reg || m_tready, "result overwritten")
    `VRRA_ASSERT_NXT(a_wrap_zero, aclk, aresetn, cmd.commit && wrap_reg, m_entry_reg == '0, "wrapped entry not zero")

endmodule

### hdl/variable_record_ring_allocator_top.sv
// Record ring allocator: after each request the block returns the write offset, the
// oldest surviving record and the following offset. An allocating request passes a size
// calculation, a walk over the tags it overruns (one tag memory read and one pointer step
// each) and a finish state that commits the result; an ignored request goes from the
// calculation to the finish state. s_tready is high only while idle. A result waiting on
// m_tready holds the next request in the finish state. After reset the tag memory is
// cleared entry by entry, during which s_tready stays low; configuration writes are
// accepted at any time and belong between requests.
// Top level; depends on vrra_pkg, vrra_ctrl and vrra_datapath.
module variable_record_ring_allocator_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [2:0] record_type
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [11:0] entry_offset, [23:12] oldest_offset,
                                   // [36:24] next_offset, [37] wrapped
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [12:0] cfg_data
);

    vrra_pkg::cmd_t    cmd;
    vrra_pkg::status_t sts;

    logic [vrra_pkg::ADDR_W-1:0] entry_offset, oldest_offset;
    logic [vrra_pkg::PTR_W-1:0]  next_offset;
    logic                        wrapped;

    assign cfg_ready = 1'b1;

    vrra_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    vrra_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_record_type   (s_tdata[vrra_pkg::TYPE_W-1:0]),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .m_tready        (m_tready),
        .m_tvalid        (m_tvalid),
        .m_entry_offset  (entry_offset),
        .m_oldest_offset (oldest_offset),
        .m_next_offset   (next_offset),
        .m_wrapped       (wrapped)
    );

    assign m_tdata = {2'b00, wrapped, next_offset, oldest_offset, entry_offset};

endmodule

### bench/tb.sv
// Testbench for variable_record_ring_allocator_top: random and directed record requests,
// each checked against a cycle-free allocation predictor held in a small scoreboard class.
// Depends on vrra_pkg and the allocator RTL; nothing else.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [vrra_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [vrra_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam logic [vrra_pkg::TYPE_W-1:0]    TYPE_BAD_LO  = 3'd6;
    localparam logic [vrra_pkg::TYPE_W-1:0]    TYPE_BAD_HI  = 3'd7;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 112;
    localparam int NUM_PHASES  = 6;

    typedef struct packed {
        logic [11:0] entry;
        logic [11:0] oldest;
        logic [12:0] next;
        logic        wrapped;
    } alloc_t;

    class alloc_scoreboard;
        logic [vrra_pkg::CFG_DAT_W-1:0] regs [6];
        int unsigned                    write_pt;
        int unsigned                    oldest_pt;
        logic [vrra_pkg::TYPE_W-1:0]    tags [vrra_pkg::BUF_BYTES];
        alloc_t                         pending_allocs [$];
        int                             errors;

        function void reset_state();
            regs = '{13'd4096, 13'd24, 13'd32, 13'd24, 13'd24, 13'd16};
            write_pt  = 0;
            oldest_pt = 0;
            errors    = 0;
            foreach (tags[i]) tags[i] = vrra_pkg::TYPE_EMPTY;
            pending_allocs.delete();
        endfunction

        function void write_reg(input logic [vrra_pkg::CFG_IDX_W-1:0] idx,
                                input logic [vrra_pkg::CFG_DAT_W-1:0] val);
            if (idx == vrra_pkg::REG_BUFFER_BYTES)
                regs[idx] = val;
            else if (idx <= vrra_pkg::REG_SIZE_LINK)
                regs[idx] = {5'd0, val[7:0]};
        endfunction

        function int unsigned rec_bytes(input logic [vrra_pkg::TYPE_W-1:0] t);
            case (t)
                vrra_pkg::TYPE_DURATION:     return 32'(regs[vrra_pkg::REG_SIZE_DURATION]);
                vrra_pkg::TYPE_DURATION_COL: return 32'(regs[vrra_pkg::REG_SIZE_DUR_COL]);
                vrra_pkg::TYPE_INSTANT:      return 32'(regs[vrra_pkg::REG_SIZE_INSTANT]);
                vrra_pkg::TYPE_COUNTER:      return 32'(regs[vrra_pkg::REG_SIZE_COUNTER]);
                vrra_pkg::TYPE_LINK:         return 32'(regs[vrra_pkg::REG_SIZE_LINK]);
                default:                     return 0;
            endcase
        endfunction

        function void predict_alloc(input logic [vrra_pkg::TYPE_W-1:0] rtype);
            int unsigned ring, rsize, entry, nxt, start, step;
            alloc_t res;
            ring = 32'(regs[vrra_pkg::REG_BUFFER_BYTES]);
            if (ring < 1) ring = 1;
            if (ring > vrra_pkg::BUF_BYTES) ring = vrra_pkg::BUF_BYTES;
            rsize = rec_bytes(rtype);
            if (rsize == 0 || rsize > ring) begin
                res.entry   = '0;
                res.oldest  = oldest_pt[11:0];
                res.next    = write_pt[12:0];
                res.wrapped = 1'b0;
                pending_allocs.push_back(res);
                return;
            end
            if (write_pt > ring || ring - write_pt < rsize) begin
                // tail marked empty only if the old write point is inside the ring
                if (write_pt < ring) tags[write_pt] = vrra_pkg::TYPE_EMPTY;
                entry       = 0;
                start       = 0;
                nxt         = rsize;
                res.wrapped = 1'b1;
            end else begin
                entry       = write_pt;
                start       = oldest_pt;
                nxt         = entry + rsize;
                res.wrapped = 1'b0;
            end
            while (start >= entry && start < nxt) begin
                step = rec_bytes(tags[start]);
                if (step == 0) begin
                    start = 0;
                    break;
                end
                start += step;
            end
            if (start >= ring) start = 0;
            tags[entry] = rtype;
            write_pt    = nxt;
            oldest_pt   = start;
            res.entry   = entry[11:0];
            res.oldest  = start[11:0];
            res.next    = nxt[12:0];
            pending_allocs.push_back(res);
        endfunction

        function int pending();
            return pending_allocs.size();
        endfunction

        function void compare_field(input string name, input logic [12:0] expv,
                                    input logic [12:0] actv);
            if (actv !== expv) begin
                $display("%0t: %s expected %0d got %0d", $time, name, expv, actv);
                errors++;
            end
        endfunction

        function void check_result(input logic [39:0] d);
            alloc_t e;
            if (pending_allocs.size() == 0) begin
                $display("%0t: result transfer expected none got %h", $time, d);
                errors++;
                return;
            end
            e = pending_allocs.pop_front();
            compare_field("entry_offset",  {1'b0, e.entry},  {1'b0, d[11:0]});
            compare_field("oldest_offset", {1'b0, e.oldest}, {1'b0, d[23:12]});
            compare_field("next_offset",   e.next,           d[36:24]);
            compare_field("wrapped",       {12'd0, e.wrapped}, {12'd0, d[37]});
        endfunction
    endclass

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [12:0] cfg_data  = '0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int          quiet_cycles   = 0;

    alloc_scoreboard sb;

    variable_record_ring_allocator_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 aclk = ~aclk;

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_request(input logic [vrra_pkg::TYPE_W-1:0] rtype);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'd0, rtype};
        do @(posedge aclk); while (!s_tready);
        sb.predict_alloc(rtype);
        @(negedge aclk);
    endtask

    task automatic write_cfg(input logic [vrra_pkg::CFG_IDX_W-1:0] idx,
                             input logic [vrra_pkg::CFG_DAT_W-1:0] val,
                             input bit last);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge aclk);
        if (last) cfg_valid <= 1'b0;
    endtask

    task automatic load_config(input logic [12:0] ring, input logic [12:0] s1,
                               input logic [12:0] s2, input logic [12:0] s3,
                               input logic [12:0] s4, input logic [12:0] s5);
        write_cfg(vrra_pkg::REG_BUFFER_BYTES,  ring, 1'b0);
        write_cfg(vrra_pkg::REG_SIZE_DURATION, s1,   1'b0);
        write_cfg(vrra_pkg::REG_SIZE_DUR_COL,  s2,   1'b0);
        write_cfg(vrra_pkg::REG_SIZE_INSTANT,  s3,   1'b0);
        write_cfg(vrra_pkg::REG_SIZE_COUNTER,  s4,   1'b0);
        write_cfg(vrra_pkg::REG_SIZE_LINK,     s5,   1'b1);
    endtask

    // drop the request line, wait out every outstanding result
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // size register value; upper data bits are don't-care and randomized
    function automatic logic [12:0] pick_size();
        logic [4:0] hi;
        logic [7:0] sz;
        hi = 5'($urandom);
        case ($urandom_range(19))
            0:          sz = 8'd0;
            1:          sz = 8'd1;
            2:          sz = 8'd255;
            3, 4, 5, 6: sz = 8'($urandom_range(1, 8));
            default:    sz = 8'($urandom_range(1, 255));
        endcase
        return {hi, sz};
    endfunction

    initial begin
        logic [vrra_pkg::TYPE_W-1:0] opening [11];
        logic [vrra_pkg::TYPE_W-1:0] rtype;
        logic [12:0]                 ring;
        logic [12:0]                 dur;
        logic [4:0]                  hi;
        int unsigned                 lim;
        int                          n;

        opening = '{vrra_pkg::TYPE_DURATION, vrra_pkg::TYPE_DURATION_COL,
                    vrra_pkg::TYPE_INSTANT, vrra_pkg::TYPE_COUNTER, vrra_pkg::TYPE_LINK,
                    vrra_pkg::TYPE_EMPTY, TYPE_BAD_LO, TYPE_BAD_HI,
                    vrra_pkg::TYPE_DURATION_COL, vrra_pkg::TYPE_DURATION_COL,
                    vrra_pkg::TYPE_DURATION};
        sb = new;
        sb.reset_state();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        // directed: unused register indexes, small ring with tail marking and walks
        write_cfg(REG_SPARE_LO, 13'h1abc, 1'b0);
        write_cfg(REG_SPARE_HI, 13'h0543, 1'b0);
        load_config(13'd100, 13'd24, 13'd32, 13'd24, 13'd24, 13'd16);
        foreach (opening[i]) send_request(opening[i]);
        drain();

        // ring shrunk below the write point; oldest pointer wraps at ring end
        write_cfg(vrra_pkg::REG_BUFFER_BYTES, 13'd40, 1'b1);
        send_request(vrra_pkg::TYPE_LINK);
        send_request(vrra_pkg::TYPE_DURATION);
        drain();

        // ring size zero clamps to one: record too large
        write_cfg(vrra_pkg::REG_BUFFER_BYTES, 13'd0, 1'b1);
        send_request(vrra_pkg::TYPE_DURATION);
        drain();
        write_cfg(vrra_pkg::REG_SIZE_DURATION, 13'd1, 1'b1);
        send_request(vrra_pkg::TYPE_DURATION);
        drain();

        // oversize ring clamps to the full buffer; zero-size type is ignored
        write_cfg(vrra_pkg::REG_BUFFER_BYTES, 13'd8191, 1'b0);
        write_cfg(vrra_pkg::REG_SIZE_DURATION, 13'd255, 1'b0);
        write_cfg(vrra_pkg::REG_SIZE_LINK, 13'd0, 1'b1);
        send_request(vrra_pkg::TYPE_LINK);
        send_request(vrra_pkg::TYPE_DURATION);
        drain();

        // stored tags whose size later becomes zero act as empty
        load_config(13'd64, 13'd24, 13'd32, 13'd24, 13'd24, 13'd16);
        repeat (5) send_request(vrra_pkg::TYPE_LINK);
        drain();
        write_cfg(vrra_pkg::REG_SIZE_LINK, 13'd0, 1'b1);
        send_request(vrra_pkg::TYPE_DURATION);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5: ring = 13'($urandom_range(1, 300));
                6, 7:             ring = 13'($urandom_range(301, 4095));
                8:                ring = 13'd4096;
                default:          ring = 13'($urandom_range(4097, 8191));
            endcase
            lim = (ring > 13'd255) ? 255 : 32'(ring);
            hi  = 5'($urandom);
            dur = {hi, 8'($urandom_range(1, lim))};
            load_config(ring, dur, pick_size(), pick_size(), pick_size(), pick_size());

            case (p % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 78;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 78;
                end
                default: begin
                    send_idle_pct  = 7;
                    recv_stall_pct = 7;
                end
            endcase
            if (p == 0) hold_req = 1'b1;

            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(2))
                        0:       rtype = vrra_pkg::TYPE_EMPTY;
                        1:       rtype = TYPE_BAD_LO;
                        default: rtype = TYPE_BAD_HI;
                    endcase
                end else begin
                    rtype = 3'($urandom_range(1, 5));
                end
                send_request(rtype);
                n++;
            end
            drain();
        end

        repeat (16) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
